### design/bounded_linked_list_engine_unit_macros.svh
// ============================================================================
// Assertion macros for the linked list engine
// Shared property wrappers, clocked on clk with synchronous reset rst_n.
// ============================================================================
`ifndef BOUNDED_LINKED_LIST_ENGINE_UNIT_MACROS_SVH
`define BOUNDED_LINKED_LIST_ENGINE_UNIT_MACROS_SVH

// Assert an implication each clock edge outside reset.
`define BLL_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Assert an implication whose consequent is checked in the next cycle.
`define BLL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/bll_pkg.sv
// ============================================================================
// bll_pkg
// Types and constants shared by the linked list engine modules.
// ============================================================================
package bll_pkg;

  localparam int unsigned PtrW  = 7;
  localparam int unsigned ValW  = 32;
  localparam logic [PtrW-1:0] NullLink = 7'h7f;

  typedef enum logic [2:0] {
    OP_INS_FRONT = 3'd0,
    OP_INS_BACK  = 3'd1,
    OP_INS_AT    = 3'd2,
    OP_DEL_FRONT = 3'd3,
    OP_DEL_BACK  = 3'd4,
    OP_DEL_AT    = 3'd5,
    OP_DUMP      = 3'd6,
    OP_NOP       = 3'd7
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_BAD_POS = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  typedef struct packed {
    logic [2:0]      opcode;
    logic [PtrW-1:0] position;
    logic [ValW-1:0] item_value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]      status;
    logic [ValW-1:0] element;
    logic            last;
    logic [PtrW-1:0] length;
  } out_item_t;

  typedef enum logic [3:0] {
    S_INIT,    // chain link memory into free list
    S_IDLE,
    S_DECODE,  // decide, issue first read
    S_WALK,    // follow links toward predecessor
    S_INS_A,   // read link of predecessor / free head
    S_INS_B,
    S_DEL_A,
    S_DEL_B,
    S_DEL_C,   // push victim onto free list
    S_DUMP,
    S_RESULT   // hand single result to output register
  } fsm_t;

endpackage

### design/bll_ram.sv
// ============================================================================
// bll_ram
// Generic two-port RAM, one write and one read per cycle, registered read.
// ============================================================================
module bll_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### design/bounded_linked_list_engine_unit.sv
// Each request is accepted, decoded and then handed to the result register.
// A rejected request goes straight to the result; a front insert/delete needs
// no walk, one at position 1 or more first follows links to its predecessor;
// back ops count the new or last node's position. Dump: one element per
// cycle while out_ready holds. The walk length bounds each request's time.
// One request at a time: the next is taken once the result is in the output
// register. Reset: a pass chains the link memory as the free list; in_ready stays low meanwhile.
// ============================================================================
// bounded_linked_list_engine_unit
// Bounded singly linked list: element and link memories plus a sequencer.
// ============================================================================
module bounded_linked_list_engine_unit #(
  parameter int unsigned CAPACITY   = 64,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  bll_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output bll_pkg::out_item_t  out_data
);
  `include "bounded_linked_list_engine_unit_macros.svh"

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned PW = bll_pkg::PtrW;
  localparam logic [PW-1:0] CapP = PW'(CAPACITY);

  // Link values at or above CAPACITY map to slot 0 (corrupt link rule).
  function automatic logic [AW-1:0] slot_f(input logic [PW-1:0] v);
    return (v < CapP) ? v[AW-1:0] : '0;
  endfunction

  bll_pkg::fsm_t state_r, state_nxt;

  logic [PW-1:0] head_r, head_nxt, free_r, free_nxt, cnt_r, cnt_nxt;
  logic [PW-1:0] steps_r, steps_nxt;     // links still to follow / dump count
  logic [AW-1:0] cur_r, cur_nxt;         // node index in hand
  logic [AW-1:0] node_r, node_nxt;       // node taken or victim
  logic          ins_r, ins_nxt;         // walking for insert
  logic [2:0]    op_r, op_nxt;
  logic [PW-1:0] pos_r, pos_nxt;
  logic [DATA_WIDTH-1:0] val_r, val_nxt;
  logic [1:0]    st_r, st_nxt;

  // Output register
  logic                 ov_r, ov_nxt;
  bll_pkg::out_item_t   od_r, od_nxt;

  // Memories
  logic                  lk_we, el_we;
  logic [AW-1:0]         lk_wa, lk_ra, el_wa, el_ra;
  logic [PW-1:0]         lk_wd, lk_rd;
  logic [DATA_WIDTH-1:0] el_wd, el_rd;

  bll_ram #(.WIDTH(PW), .DEPTH(CAPACITY)) u_link (
    .clk, .we(lk_we), .waddr(lk_wa), .wdata(lk_wd), .raddr(lk_ra), .rdata(lk_rd)
  );
  bll_ram #(.WIDTH(DATA_WIDTH), .DEPTH(CAPACITY)) u_elem (
    .clk, .we(el_we), .waddr(el_wa), .wdata(el_wd), .raddr(el_ra), .rdata(el_rd)
  );

  logic out_free;
  assign out_free  = !ov_r || out_ready;
  assign in_ready  = (state_r == bll_pkg::S_IDLE);
  assign out_valid = ov_r;
  assign out_data  = od_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bll_pkg::S_INIT;
      head_r  <= bll_pkg::NullLink;
      free_r  <= '0;
      cnt_r   <= '0;
      cur_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      free_r  <= free_nxt;
      cnt_r   <= cnt_nxt;
      cur_r   <= cur_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    steps_r <= steps_nxt;
    node_r  <= node_nxt;
    ins_r   <= ins_nxt;
    op_r    <= op_nxt;
    pos_r   <= pos_nxt;
    val_r   <= val_nxt;
    st_r    <= st_nxt;
    od_r    <= od_nxt;
  end

  always_comb begin
    logic [PW-1:0] tpos;
    state_nxt = state_r;
    head_nxt = head_r; free_nxt = free_r; cnt_nxt = cnt_r;
    steps_nxt = steps_r; cur_nxt = cur_r; node_nxt = node_r; ins_nxt = ins_r;
    op_nxt = op_r; pos_nxt = pos_r; val_nxt = val_r; st_nxt = st_r;
    ov_nxt = ov_r && !out_ready;
    od_nxt = od_r;
    lk_we = 1'b0; lk_wa = cur_r; lk_wd = '0; lk_ra = cur_r;
    el_we = 1'b0; el_wa = node_r; el_wd = val_r; el_ra = cur_r;
    tpos = '0;

    unique case (state_r)
      bll_pkg::S_INIT: begin
        // cur_r sweeps all entries; entry i links to i+1, last to null
        lk_we = 1'b1;
        lk_wa = cur_r;
        lk_wd = (32'(cur_r) + 1 < CAPACITY) ? PW'(cur_r) + PW'(1) : bll_pkg::NullLink;
        cur_nxt = cur_r + AW'(1);
        if (32'(cur_r) == CAPACITY - 1) begin
          cur_nxt = '0;
          state_nxt = bll_pkg::S_IDLE;
        end
      end
      bll_pkg::S_IDLE: begin
        if (in_valid) begin
          op_nxt = in_data.opcode;
          pos_nxt = in_data.position;
          val_nxt = DATA_WIDTH'(in_data.item_value);
          state_nxt = bll_pkg::S_DECODE;
        end
      end
      bll_pkg::S_DECODE: begin
        unique case (op_r) inside
          bll_pkg::OP_INS_FRONT: tpos = '0;
          bll_pkg::OP_INS_BACK: tpos = cnt_r;
          bll_pkg::OP_DEL_BACK: tpos = cnt_r - PW'(1);
          bll_pkg::OP_INS_AT, bll_pkg::OP_DEL_AT: tpos = pos_r;
          default: tpos = '0;
        endcase
        cur_nxt = slot_f(head_r);
        lk_ra = slot_f(head_r);
        el_ra = slot_f(head_r);
        state_nxt = bll_pkg::S_RESULT;
        if (op_r == bll_pkg::OP_INS_FRONT || op_r == bll_pkg::OP_INS_BACK ||
            op_r == bll_pkg::OP_INS_AT) begin
          if (cnt_r >= CapP) st_nxt = bll_pkg::ST_FULL;
          else if (tpos > cnt_r) st_nxt = bll_pkg::ST_BAD_POS;
          else begin
            ins_nxt = 1'b1;
            node_nxt = slot_f(free_r);
            el_we = 1'b1;
            el_wa = slot_f(free_r);
            steps_nxt = tpos;
            state_nxt = bll_pkg::S_INS_A;
          end
        end else if (op_r == bll_pkg::OP_DEL_FRONT || op_r == bll_pkg::OP_DEL_BACK ||
                     op_r == bll_pkg::OP_DEL_AT) begin
          if (cnt_r == '0) st_nxt = bll_pkg::ST_EMPTY;
          else if (tpos >= cnt_r) st_nxt = bll_pkg::ST_BAD_POS;
          else begin
            ins_nxt = 1'b0;
            steps_nxt = tpos;
            state_nxt = bll_pkg::S_DEL_A;
          end
        end else if (op_r == bll_pkg::OP_DUMP) begin
          if (cnt_r == '0) st_nxt = bll_pkg::ST_EMPTY;
          else begin
            steps_nxt = cnt_r;
            state_nxt = bll_pkg::S_DUMP;
          end
        end else begin
          st_nxt = bll_pkg::ST_BAD_POS;
        end
        if (state_nxt == bll_pkg::S_INS_A || state_nxt == bll_pkg::S_DEL_A) begin
          if (tpos > PW'(1)) state_nxt = bll_pkg::S_WALK;
        end
        if (state_nxt != bll_pkg::S_RESULT) begin
          // read the free head link for insert-at-front, else the head link
          lk_ra = ((state_nxt == bll_pkg::S_INS_A) && tpos == '0) ?
                  slot_f(free_r) : slot_f(head_r);
        end
      end
      bll_pkg::S_WALK: begin
        // lk_rd holds link of cur_r; predecessor is at position steps-1
        cur_nxt = slot_f(lk_rd);
        lk_ra = slot_f(lk_rd);
        steps_nxt = steps_r - PW'(1);
        if (steps_r == PW'(2)) state_nxt = ins_r ? bll_pkg::S_INS_A : bll_pkg::S_DEL_A;
      end
      bll_pkg::S_INS_A: begin
        // steps 0: lk_rd = link of free node; else cur_r is predecessor
        if (steps_r == '0) begin
          free_nxt = lk_rd;
          lk_we = 1'b1; lk_wa = node_r; lk_wd = head_r;
          head_nxt = PW'(node_r);
          cnt_nxt = cnt_r + PW'(1);
          st_nxt = bll_pkg::ST_OK;
          state_nxt = bll_pkg::S_RESULT;
        end else begin
          // lk_rd = link of predecessor; now read free node link
          pos_nxt = lk_rd;
          lk_ra = node_r;
          state_nxt = bll_pkg::S_INS_B;
        end
      end
      bll_pkg::S_INS_B: begin
        free_nxt = lk_rd;
        lk_we = 1'b1; lk_wa = node_r; lk_wd = pos_r;
        steps_nxt = '0;
        state_nxt = bll_pkg::S_DEL_B; // reuse: write prev link next cycle
        ins_nxt = 1'b1;
      end
      bll_pkg::S_DEL_A: begin
        if (steps_r == '0) begin
          // cur_r is victim, lk_rd its link
          head_nxt = lk_rd;
          node_nxt = cur_r;
          lk_we = 1'b1; lk_wa = cur_r; lk_wd = free_r;
          free_nxt = PW'(cur_r);
          cnt_nxt = cnt_r - PW'(1);
          st_nxt = bll_pkg::ST_OK;
          state_nxt = bll_pkg::S_RESULT;
        end else begin
          // cur_r is predecessor; lk_rd is victim index, read its link
          node_nxt = slot_f(lk_rd);
          lk_ra = slot_f(lk_rd);
          ins_nxt = 1'b0;
          state_nxt = bll_pkg::S_DEL_B;
        end
      end
      bll_pkg::S_DEL_B: begin
        if (ins_r) begin
          lk_we = 1'b1; lk_wa = cur_r; lk_wd = PW'(node_r);
          cnt_nxt = cnt_r + PW'(1);
          st_nxt = bll_pkg::ST_OK;
          state_nxt = bll_pkg::S_RESULT;
        end else begin
          // splice predecessor past victim; victim link written next
          lk_we = 1'b1; lk_wa = cur_r; lk_wd = lk_rd;
          cur_nxt = node_r;
          state_nxt = bll_pkg::S_DEL_C;
        end
      end
      bll_pkg::S_DEL_C: begin
        // cur_r is victim: link it to the old free head
        lk_we = 1'b1; lk_wa = cur_r; lk_wd = free_r;
        free_nxt = PW'(cur_r);
        cnt_nxt = cnt_r - PW'(1);
        st_nxt = bll_pkg::ST_OK;
        state_nxt = bll_pkg::S_RESULT;
      end
      bll_pkg::S_DUMP: begin
        // el_rd/lk_rd refer to cur_r (read issued previous cycle)
        if (out_free) begin
          ov_nxt = 1'b1;
          od_nxt.status = bll_pkg::ST_OK;
          od_nxt.element = bll_pkg::ValW'(el_rd);
          od_nxt.last = (steps_r == PW'(1));
          od_nxt.length = cnt_r;
          steps_nxt = steps_r - PW'(1);
          cur_nxt = slot_f(lk_rd);
          lk_ra = slot_f(lk_rd);
          el_ra = slot_f(lk_rd);
          if (steps_r == PW'(1)) state_nxt = bll_pkg::S_IDLE;
        end else begin
          lk_ra = cur_r;
          el_ra = cur_r;
        end
      end
      bll_pkg::S_RESULT: begin
        if (out_free) begin
          ov_nxt = 1'b1;
          od_nxt.status = st_r;
          od_nxt.element = '0;
          od_nxt.last = 1'b1;
          od_nxt.length = cnt_r;
          state_nxt = bll_pkg::S_IDLE;
        end
      end
      default: state_nxt = bll_pkg::S_IDLE;
    endcase
  end

  `BLL_ASSERT_IMPL(a_cnt_cap, 1'b1, cnt_r <= CapP, "element count above capacity")
  `BLL_ASSERT_IMPL(a_busy_no_in, state_r != bll_pkg::S_IDLE, !in_ready,
                   "ready while busy")
  `BLL_ASSERT_NEXT(a_res_valid, state_r == bll_pkg::S_RESULT && (!ov_r || out_ready),
                   out_valid && out_data.last, "single result not issued")
endmodule

### test/bounded_linked_list_engine_unit_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// bounded_linked_list_engine_unit_tb
// Drives insert, delete and dump requests into the linked list engine and
// checks every result transfer against a queue-based model of the list.
// ============================================================================
module bounded_linked_list_engine_unit_tb;
  import bll_pkg::*;

  localparam int CAP = 64;
  localparam int STALL_LIMIT = 20000;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_item_t in_data;
  logic out_valid;
  logic out_ready;
  out_item_t out_data;

  // Model: the list contents in order, as a plain queue of values.
  logic [ValW-1:0] list_model[$];
  out_item_t pending_results[$];

  int errors = 0;
  int sent = 0;
  int received = 0;
  int dumps = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int quiet_cycles = 0;

  bounded_linked_list_engine_unit DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic out_item_t make_result(status_t st, logic [ValW-1:0] el, logic lst);
    out_item_t r;
    r.status = st;
    r.element = el;
    r.last = lst;
    r.length = PtrW'(list_model.size());
    return r;
  endfunction

  // Applies one request to the model list and queues the results it causes.
  function automatic void apply_request(in_item_t req);
    int n;
    int pos;
    status_t st;
    n = list_model.size();
    pos = req.position;
    st = ST_OK;
    case (opcode_t'(req.opcode)) inside
      OP_INS_FRONT, OP_INS_BACK, OP_INS_AT: begin
        if (req.opcode == OP_INS_FRONT) pos = 0;
        else if (req.opcode == OP_INS_BACK) pos = n;
        if (n >= CAP) st = ST_FULL;
        else if (pos > n) st = ST_BAD_POS;
        else list_model.insert(pos, req.item_value);
      end
      OP_DEL_FRONT, OP_DEL_BACK, OP_DEL_AT: begin
        if (req.opcode == OP_DEL_FRONT) pos = 0;
        else if (req.opcode == OP_DEL_BACK) pos = n - 1;
        if (n == 0) st = ST_EMPTY;
        else if (pos >= n) st = ST_BAD_POS;
        else list_model.delete(pos);
      end
      OP_DUMP: begin
        if (n == 0) begin
          pending_results.push_back(make_result(ST_EMPTY, '0, 1'b1));
        end else begin
          for (int k = 0; k < n; k++)
            pending_results.push_back(make_result(ST_OK, list_model[k], k == n - 1));
        end
        return;
      end
      default: st = ST_BAD_POS;
    endcase
    pending_results.push_back(make_result(st, '0, 1'b1));
  endfunction

  // Holds valid until the transfer, with random idle cycles before it.
  task automatic send_request(opcode_t op, int pos, logic [ValW-1:0] val);
    in_item_t req;
    req.opcode = op;
    req.position = PtrW'(pos);
    req.item_value = val;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (!in_ready);
    apply_request(req);
    if (op == OP_DUMP) dumps++;
    sent++;
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Receiver side: random backpressure, checks each transfer in order.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        received++;
        if (pending_results.size() == 0) begin
          $error("unexpected result transfer: %p", out_data);
          errors++;
        end else begin
          out_item_t want;
          want = pending_results.pop_front();
          if (out_data.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_data.status);
            errors++;
          end
          if (out_data.element !== want.element) begin
            $error("element: expected %h, got %h", want.element, out_data.element);
            errors++;
          end
          if (out_data.last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, out_data.last);
            errors++;
          end
          if (out_data.length !== want.length) begin
            $error("length: expected %0d, got %0d", want.length, out_data.length);
            errors++;
          end
        end
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog on cycles without any transfer; covers the init pass too.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic logic [ValW-1:0] rand_value();
    case ($urandom_range(3))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  // Front/back/positional edge cases on a short list, plus empty checks.
  task automatic test_directed();
    send_request(OP_DUMP, 0, '0);
    send_request(OP_DEL_FRONT, 0, '0);
    send_request(OP_DEL_BACK, 0, '0);
    send_request(OP_DEL_AT, 0, '0);
    send_request(OP_INS_AT, 1, 32'h1);
    send_request(OP_INS_FRONT, 0, 32'hFFFF_FFFF);
    send_request(OP_INS_BACK, 127, 32'h0);
    send_request(OP_INS_AT, 2, 32'hA5A5_5A5A);
    send_request(OP_INS_AT, 1, 32'h5A5A_A5A5);
    send_request(OP_INS_AT, 127, 32'h1234_5678);
    send_request(OP_NOP, 127, 32'hFFFF_FFFF);
    send_request(OP_DUMP, 0, '0);
    send_request(OP_DEL_AT, 4, '0);
    send_request(OP_DEL_AT, 127, '0);
    send_request(OP_DEL_AT, 1, '0);
    send_request(OP_DEL_BACK, 0, '0);
    send_request(OP_DEL_FRONT, 0, '0);
    send_request(OP_DUMP, 0, '0);
    send_request(OP_DEL_AT, 0, '0);
    send_request(OP_DUMP, 0, '0);
  endtask

  // Fill to capacity, overflow, dump the full list, then empty it.
  task automatic test_full_list();
    while (list_model.size() < CAP)
      send_request(opcode_t'($urandom_range(2)), $urandom_range(list_model.size()),
                   $urandom);
    send_request(OP_INS_FRONT, 0, '1);
    send_request(OP_INS_AT, 127, '1);
    send_request(OP_INS_BACK, 0, '1);
    send_request(OP_DUMP, 0, '0);
    send_request(OP_DEL_AT, 63, '0);
    send_request(OP_INS_AT, 63, 32'hDEAD_BEEF);
    while (list_model.size() > 0)
      send_request(opcode_t'(OP_DEL_FRONT + $urandom_range(2)),
                   $urandom_range(list_model.size() - 1), '0);
  endtask

  // Random mix; positions mostly in range, occasionally anything.
  task automatic test_random(int count);
    opcode_t op;
    int pos;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(19))
        0, 1, 2, 3, 4, 5, 6: op = opcode_t'($urandom_range(2));
        7, 8, 9, 10, 11, 12: op = opcode_t'(OP_DEL_FRONT + $urandom_range(2));
        13: op = OP_NOP;
        default: op = ($urandom_range(3) == 0) ? OP_DUMP : opcode_t'($urandom_range(5));
      endcase
      if ($urandom_range(9) == 0) pos = $urandom_range(127);
      else pos = $urandom_range(list_model.size());
      send_request(op, pos, rand_value());
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 17; recv_idle_pct = 81;
    test_directed();
    test_random(40);
    send_idle_pct = 81; recv_idle_pct = 17;
    test_full_list();
    test_random(36);
    send_idle_pct = 0; recv_idle_pct = 0;
    test_random(40);
    in_valid <= 1'b0;
    wait_drained();
    repeat (2 * CAP + 10) @(posedge clk);

    $display("Sent %0d requests (%0d dumps), checked %0d result transfers,",
             sent, dumps, received);
    $display("including a full-capacity fill and overflow under three stall mixes.");
    if (errors == 0 && pending_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
